// ===== sv/tga_pkg.sv =====
// ----------------------------------------------------------------------------
// tga_pkg: shared types and codes of the TGA decoder
// Request payloads of the byte input and the record output, record kinds
// and status codes.
// ----------------------------------------------------------------------------
package tga_pkg;

	// record kinds
	localparam logic [1:0] KIND_RUN   = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
	localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
	localparam logic [2:0] ST_BAD_MAP   = 3'd3;
	localparam logic [2:0] ST_SHORT     = 3'd4;

	localparam int unsigned HDR_LEN   = 18;
	localparam logic [7:0]  RLE_SPLIT = 8'd127;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [2:0]  status_code;
		logic [31:0] argb_pixel;
		logic [15:0] dest_row;
		logic [15:0] dest_column;
		logic [7:0]  run_length;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        last_of_step;
	} rec_t;

endpackage

// ===== sv/tga_stream_if.sv =====
// ----------------------------------------------------------------------------
// tga_stream_if: valid/ready channel
// One request moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface tga_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/tga_image_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_image_decoder: TGA file to ARGB pixel runs
// Records: a byte's records are held in stage 1 on accept and written to the
// output queue in the cycle after, from where they can leave.
// Throughput: one byte per cycle while the output queue has room; a run that wraps
// past two or more image rows holds the input while the row/column update unit steps the rows.
// Reset: asynchronous, returns to the header phase; palette reads as zero.
// ----------------------------------------------------------------------------
module tga_image_decoder
	import tga_pkg::*;
#(
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	tga_stream_if.sink   in_ch,
	tga_stream_if.source out_ch
);

	localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	localparam logic [2:0] PH_HEADER  = 3'd0;
	localparam logic [2:0] PH_PALETTE = 3'd1;
	localparam logic [2:0] PH_PACKET  = 3'd2;
	localparam logic [2:0] PH_PIXEL   = 3'd3;
	localparam logic [2:0] PH_IDLE    = 3'd4;

	// state registers
	logic [7:0]  hdr_q [17];
	logic [4:0]  pos_q;
	logic [2:0]  phase_q;
	logic [31:0] asm_q;
	logic [1:0]  bip_q;
	logic [7:0]  rem_q;
	logic        rep_q;
	logic [31:0] pdone_q;
	logic [15:0] row_q;
	logic [15:0] col_q;
	logic [31:0] total_q;
	logic [7:0]  ent_q;
	logic [PALETTE_DEPTH-1:0] pvalid_q;
	logic        busy_q;
	logic [16:0] div_q;

	logic [7:0]  hdr_n [17];
	logic [4:0]  pos_n;
	logic [2:0]  phase_n;
	logic [31:0] asm_n;
	logic [1:0]  bip_n;
	logic [7:0]  rem_n;
	logic        rep_n;
	logic [31:0] pdone_n;
	logic [15:0] row_n;
	logic [15:0] col_n;
	logic [31:0] total_n;
	logic [7:0]  ent_n;
	logic [PALETTE_DEPTH-1:0] pvalid_n;
	logic        busy_n;
	logic [16:0] div_n;

	// palette memory
	logic [31:0] pal_mem [PALETTE_DEPTH];
	logic [31:0] pal_rdata_q;
	logic        pal_we;
	logic [31:0] pal_wdata;
	logic        pal_re;
	logic [AW-1:0] pal_ridx;

	// stage 1 records
	logic [1:0] n_rec;
	rec_t       rec0, rec1;
	logic       map_rd, map_ok;
	logic [1:0] n_s1;
	rec_t       rec0_s1, rec1_s1;
	logic       map_s1, ok_s1;

	// output queue
	rec_t       fifo_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	logic acc, pop;
	logic [7:0] b;
	logic       eof;

	// header fields
	logic [15:0] w, h;
	logic        rle, mapped;
	logic [4:0]  esize, pbytes;
	logic [7:0]  mcount;
	logic [2:0]  hstat;

	assign w      = {hdr_q[13], hdr_q[12]};
	assign h      = {hdr_q[15], hdr_q[14]};
	assign rle    = (hdr_q[2] == 8'd9) || (hdr_q[2] == 8'd10);
	assign mapped = (hdr_q[2] == 8'd1) || (hdr_q[2] == 8'd9);
	assign esize  = hdr_q[7][7:3];
	assign mcount = (hdr_q[1] != 8'd0) ? hdr_q[5] : 8'd0;
	assign pbytes = mapped ? 5'd1 : hdr_q[16][7:3];

	// header checks in priority order
	always_comb begin
		if (w == 16'd0 || h == 16'd0) begin
			hstat = ST_ZERO_SIZE;
		end else if (mapped) begin
			hstat = (hdr_q[6] != 8'd0 || hdr_q[4] != 8'd0 || hdr_q[3] != 8'd0 ||
				(hdr_q[7] != 8'd24 && hdr_q[7] != 8'd32)) ? ST_BAD_MAP : ST_OK;
		end else if (hdr_q[2] == 8'd2 || hdr_q[2] == 8'd10) begin
			hstat = (hdr_q[5] != 8'd0 || hdr_q[6] != 8'd0 || hdr_q[1] != 8'd0 ||
				(hdr_q[16] != 8'd24 && hdr_q[16] != 8'd32)) ? ST_BAD_MAP : ST_OK;
		end else begin
			hstat = ST_BAD_TYPE;
		end
	end

	// byte gathering into a pixel word
	function automatic logic gather_done(input logic [1:0] nb, input logic [4:0] size);
		logic r;
		begin
			case (size)
				5'd1:    r = 1'b1;
				5'd2:    r = ~nb[0];
				5'd3:    r = (nb == 2'd3);
				5'd4:    r = (nb == 2'd0);
				default: r = 1'b0;
			endcase
			return r;
		end
	endfunction

	assign in_ch.ready = !busy_q && ({1'b0, cnt_q} + {2'b00, n_s1} <= 4'd2);
	assign acc = in_ch.valid && in_ch.ready;
	assign b   = in_ch.data.file_byte;
	assign eof = in_ch.data.end_of_file;

	// per-byte decode
	always_comb begin
		logic [31:0] g_val;
		logic [1:0]  g_nb;
		logic        g_done;
		logic [4:0]  g_size;
		logic [7:0]  cnt;
		logic [31:0] left;
		logic [16:0] sum, s2;
		logic [15:0] orow;
		logic [1:0]  nr;

		hdr_n    = hdr_q;
		pos_n    = pos_q;
		phase_n  = phase_q;
		asm_n    = asm_q;
		bip_n    = bip_q;
		rem_n    = rem_q;
		rep_n    = rep_q;
		pdone_n  = pdone_q;
		row_n    = row_q;
		col_n    = col_q;
		total_n  = total_q;
		ent_n    = ent_q;
		pvalid_n = pvalid_q;
		busy_n   = busy_q;
		div_n    = div_q;
		pal_we   = 1'b0;
		pal_re   = 1'b0;
		pal_wdata = '0;
		pal_ridx = '0;
		map_rd   = 1'b0;
		map_ok   = 1'b0;
		rec0     = '0;
		rec1     = '0;
		nr       = 2'd0;
		cnt      = 8'd0;
		left     = '0;
		sum      = '0;
		s2       = '0;
		orow     = '0;

		g_size = (phase_q == PH_PALETTE) ? esize : pbytes;
		g_nb   = bip_q + 2'd1;
		g_done = gather_done(g_nb, g_size);
		g_val  = asm_q | ({24'd0, b} << {bip_q, 3'b000});
		if (g_size == 5'd3) begin
			g_val[31:24] = 8'hFF;
		end

		// row/column update for runs spanning several rows
		if (busy_q) begin
			if (div_q >= {1'b0, w}) begin
				div_n = div_q - {1'b0, w};
				row_n = row_q + 16'd1;
			end else begin
				col_n  = div_q[15:0];
				busy_n = 1'b0;
			end
		end

		if (acc) begin
			case (phase_q)
				PH_HEADER: begin
					if (pos_q < 5'd17) begin
						hdr_n[pos_q] = b;
					end
					pos_n = pos_q + 5'd1;
					if (pos_q == 5'(HDR_LEN - 1)) begin
						if (hstat != ST_OK) begin
							rec0.record_kind = KIND_ERROR;
							rec0.status_code = hstat;
							nr = 2'd1;
							phase_n = PH_IDLE;
						end else begin
							pvalid_n = '0;
							pdone_n  = '0;
							row_n    = '0;
							col_n    = '0;
							asm_n    = '0;
							bip_n    = '0;
							rem_n    = '0;
							rep_n    = 1'b0;
							ent_n    = '0;
							total_n  = w * h;
							if (mcount != 8'd0) begin
								phase_n = PH_PALETTE;
							end else begin
								phase_n = rle ? PH_PACKET : PH_PIXEL;
							end
						end
					end
				end
				PH_PALETTE: begin
					asm_n = asm_q | ({24'd0, b} << {bip_q, 3'b000});
					bip_n = g_nb;
					if (g_done) begin
						asm_n = '0;
						bip_n = '0;
						if ({1'b0, ent_q} < 9'(PALETTE_DEPTH)) begin
							pal_we    = 1'b1;
							pal_wdata = g_val;
							pvalid_n[ent_q[AW-1:0]] = 1'b1;
						end
						ent_n = ent_q + 8'd1;
						if (ent_n == mcount) begin
							phase_n = rle ? PH_PACKET : PH_PIXEL;
						end
					end
				end
				PH_PACKET: begin
					rep_n   = b > RLE_SPLIT;
					rem_n   = (b > RLE_SPLIT) ? (b - RLE_SPLIT) : (b + 8'd1);
					asm_n   = '0;
					bip_n   = '0;
					phase_n = PH_PIXEL;
				end
				PH_PIXEL: begin
					asm_n = asm_q | ({24'd0, b} << {bip_q, 3'b000});
					bip_n = g_nb;
					if (g_done) begin
						asm_n = '0;
						bip_n = '0;
						if (mapped) begin
							map_rd   = 1'b1;
							pal_re   = 1'b1;
							pal_ridx = g_val[AW-1:0];
							map_ok   = ({1'b0, g_val[7:0]} < 9'(PALETTE_DEPTH)) &&
								pvalid_q[g_val[AW-1:0]];
						end
						cnt  = (rle && rep_q) ? rem_q : 8'd1;
						left = total_q - pdone_q;
						if ({24'd0, cnt} > left) begin
							cnt = left[7:0];
						end
						orow = ({hdr_q[11], hdr_q[10]} == 16'd0) ? (h - 16'd1 - row_q) : row_q;
						rec0.record_kind = KIND_RUN;
						rec0.status_code = ST_OK;
						rec0.argb_pixel  = g_val;
						rec0.dest_row    = orow;
						rec0.dest_column = col_q;
						rec0.run_length  = cnt;
						nr = 2'd1;
						pdone_n = pdone_q + {24'd0, cnt};
						// advance the destination position
						sum = {1'b0, col_q} + {9'd0, cnt};
						if (sum < {1'b0, w}) begin
							col_n = sum[15:0];
						end else begin
							s2    = sum - {1'b0, w};
							row_n = row_q + 16'd1;
							if (s2 < {1'b0, w}) begin
								col_n = s2[15:0];
							end else begin
								div_n  = s2;
								busy_n = 1'b1;
							end
						end
						if (rle) begin
							if (rep_q || rem_q <= 8'd1) begin
								rem_n = 8'd0;
							end else begin
								rem_n = rem_q - 8'd1;
							end
							if (rem_n == 8'd0) begin
								phase_n = PH_PACKET;
							end
						end
						if (pdone_n >= total_q) begin
							rec1.record_kind  = KIND_DONE;
							rec1.image_width  = w;
							rec1.image_height = h;
							nr = 2'd2;
							phase_n = PH_IDLE;
						end
					end
				end
				default: begin
				end
			endcase

			// end of file closes the current file
			if (eof) begin
				if (phase_n != PH_IDLE) begin
					if (nr == 2'd0) begin
						rec0.record_kind = KIND_ERROR;
						rec0.status_code = ST_SHORT;
					end else begin
						rec1.record_kind = KIND_ERROR;
						rec1.status_code = ST_SHORT;
					end
					nr = nr + 2'd1;
				end
				pos_n   = '0;
				asm_n   = '0;
				bip_n   = '0;
				rem_n   = '0;
				rep_n   = 1'b0;
				phase_n = PH_HEADER;
			end
			if (nr == 2'd1) begin
				rec0.last_of_step = 1'b1;
			end
			if (nr == 2'd2) begin
				rec1.last_of_step = 1'b1;
			end
		end
		n_rec = nr;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= PH_HEADER;
			asm_q    <= '0;
			bip_q    <= '0;
			rem_q    <= '0;
			rep_q    <= 1'b0;
			pdone_q  <= '0;
			row_q    <= '0;
			col_q    <= '0;
			total_q  <= '0;
			ent_q    <= '0;
			pvalid_q <= '0;
			busy_q   <= 1'b0;
			div_q    <= '0;
			n_s1     <= '0;
		end else begin
			pos_q    <= pos_n;
			phase_q  <= phase_n;
			asm_q    <= asm_n;
			bip_q    <= bip_n;
			rem_q    <= rem_n;
			rep_q    <= rep_n;
			pdone_q  <= pdone_n;
			row_q    <= row_n;
			col_q    <= col_n;
			total_q  <= total_n;
			ent_q    <= ent_n;
			pvalid_q <= pvalid_n;
			busy_q   <= busy_n;
			div_q    <= div_n;
			n_s1     <= n_rec;
		end
	end

	// header bytes and stage 1 payload
	always_ff @(posedge clk) begin
		hdr_q   <= hdr_n;
		rec0_s1 <= rec0;
		rec1_s1 <= rec1;
		map_s1  <= map_rd;
		ok_s1   <= map_ok;
	end

	// palette memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[ent_q[AW-1:0]] <= pal_wdata;
		end
		if (pal_re) begin
			pal_rdata_q <= pal_mem[pal_ridx];
		end
	end

	// output queue
	always_comb begin
		pop = (cnt_q != 3'd0) && out_ch.ready;
	end

	assign out_ch.valid = (cnt_q != 3'd0);
	assign out_ch.data  = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		rec_t r0;
		r0 = rec0_s1;
		if (map_s1) begin
			r0.argb_pixel = ok_s1 ? pal_rdata_q : 32'd0;
		end
		if (n_s1 != 2'd0) begin
			fifo_q[wp_q] <= r0;
		end
		if (n_s1 == 2'd2) begin
			fifo_q[wp_q + 2'd1] <= rec1_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + n_s1;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, n_s1} - {2'b00, pop};
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: TGA decoder testbench
// Streams whole TGA files (good and broken headers, mapped and true colour,
// raw and run-length coded, short and overlong) into the decoder. A local
// decoder predicts the records of every file byte; records are checked in
// order against it, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
	import tga_pkg::*;

	localparam int unsigned PAL_DEPTH = 256;
	localparam int unsigned N_TARGET  = 1050;

	// local decoder phases
	typedef enum logic [2:0] {P_HEADER, P_PALETTE, P_PACKET, P_PIXEL, P_IDLE} phase_e;

	logic clk;
	logic arst_n;

	tga_stream_if #(.T(in_item_t)) in_ch ();
	tga_stream_if #(.T(rec_t))     out_ch ();

	tga_image_decoder #(.PALETTE_DEPTH(PAL_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// clock and reset
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		clk    = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// decoder state
	logic [7:0]  hdr [HDR_LEN];
	logic [31:0] pos;
	logic [31:0] pal [PAL_DEPTH];
	logic [31:0] asm_word;
	logic [1:0]  asm_cnt;
	logic [7:0]  pkt_left;
	logic        pkt_rep;
	logic [31:0] px_done;
	logic [15:0] cur_row;
	logic [15:0] cur_col;
	phase_e      phase;

	rec_t      expected_recs [$];
	in_item_t  pending_bytes [$];
	int        errors;
	int        mismatches;
	int        pushed_total;
	bit        hold_until_drained;
	bit        no_idle;

	function automatic logic [15:0] hdr_word(int lo);
		return {hdr[lo + 1], hdr[lo]};
	endfunction

	function automatic bit rle_type();
		return hdr[2] == 8'd9 || hdr[2] == 8'd10;
	endfunction

	function automatic bit mapped_type();
		return hdr[2] == 8'd1 || hdr[2] == 8'd9;
	endfunction

	function automatic logic [31:0] map_entries();
		return hdr[1] != 0 ? 32'(hdr[5]) : 32'd0;
	endfunction

	function automatic logic [2:0] header_check();
		if (hdr_word(12) == 0 || hdr_word(14) == 0) return ST_ZERO_SIZE;
		if (hdr[2] == 8'd1 || hdr[2] == 8'd9) begin
			if (hdr[6] != 0 || hdr[4] != 0 || hdr[3] != 0 ||
			    (hdr[7] != 8'd24 && hdr[7] != 8'd32)) return ST_BAD_MAP;
			return ST_OK;
		end
		if (hdr[2] == 8'd2 || hdr[2] == 8'd10) begin
			if (hdr[5] != 0 || hdr[6] != 0 || hdr[1] != 0 ||
			    (hdr[16] != 8'd24 && hdr[16] != 8'd32)) return ST_BAD_MAP;
			return ST_OK;
		end
		return ST_BAD_TYPE;
	endfunction

	function automatic rec_t make_rec(logic [1:0] kind, logic [2:0] st);
		rec_t r;
		r = '0;
		r.record_kind = kind;
		r.status_code = st;
		return r;
	endfunction

	function automatic void clear_pixel_state();
		asm_word = '0;
		asm_cnt  = '0;
		pkt_left = '0;
		pkt_rep  = 1'b0;
	endfunction

	// byte into the pixel word; returns 1 when a word of size bytes completes
	function automatic bit assemble(logic [7:0] b, int unsigned size,
	                                output logic [31:0] word);
		asm_word = asm_word | (32'(b) << (8 * asm_cnt));
		asm_cnt  = asm_cnt + 2'd1;
		word     = '0;
		if (size == 0 || (int'(asm_cnt) % size) != 0) begin
			if (asm_cnt != 0 || size != 4) return 0;
		end
		word = asm_word;
		if (size == 3) word[31:24] = 8'hFF;
		asm_word = '0;
		asm_cnt  = '0;
		return 1;
	endfunction

	function automatic void restart_file();
		pos   = '0;
		clear_pixel_state();
		phase = P_HEADER;
	endfunction

	function automatic void decode_reset();
		foreach (hdr[i]) hdr[i] = '0;
		foreach (pal[i]) pal[i] = '0;
		px_done = '0;
		cur_row = '0;
		cur_col = '0;
		restart_file();
	endfunction

	// predicted records of one accepted byte
	function automatic void decode_byte(in_item_t it);
		rec_t        out_recs [$];
		rec_t        r;
		logic [7:0]  b;
		logic [31:0] word, cnt, total, left, w, h, sum, idx, esize, psize;
		logic [2:0]  st;
		b = it.file_byte;
		case (phase)
			P_HEADER: begin
				if (pos < HDR_LEN) hdr[pos] = b;
				pos = pos + 1;
				if (pos >= HDR_LEN) begin
					st = header_check();
					if (st != ST_OK) begin
						out_recs.push_back(make_rec(KIND_ERROR, st));
						phase = P_IDLE;
					end else begin
						foreach (pal[i]) pal[i] = '0;
						px_done = '0;
						cur_row = '0;
						cur_col = '0;
						clear_pixel_state();
						if (map_entries() != 0) phase = P_PALETTE;
						else phase = rle_type() ? P_PACKET : P_PIXEL;
					end
				end
			end
			P_PALETTE: begin
				esize = 32'(hdr[7] >> 3);
				if (assemble(b, esize, word) && esize != 0) begin
					idx = (pos - HDR_LEN) / esize;
					if (idx < PAL_DEPTH) pal[idx] = word;
				end
				pos = pos + 1;
				if (pos >= HDR_LEN + map_entries() * esize)
					phase = rle_type() ? P_PACKET : P_PIXEL;
			end
			P_PACKET: begin
				pkt_rep  = b > RLE_SPLIT;
				pkt_left = pkt_rep ? b - RLE_SPLIT : b + 8'd1;
				asm_word = '0;
				asm_cnt  = '0;
				phase    = P_PIXEL;
			end
			P_PIXEL: begin
				psize = mapped_type() ? 32'd1 : 32'(hdr[16] >> 3);
				if (assemble(b, psize, word)) begin
					w = 32'(hdr_word(12));
					h = 32'(hdr_word(14));
					if (mapped_type()) word = pal[word[7:0]];
					cnt   = (rle_type() && pkt_rep) ? 32'(pkt_left) : 32'd1;
					total = w * h;
					left  = total - px_done;
					if (cnt > left) cnt = left;
					r = make_rec(KIND_RUN, ST_OK);
					r.argb_pixel  = word;
					r.dest_row    = (hdr_word(10) == 0) ? 16'(h - 1 - cur_row) : cur_row;
					r.dest_column = cur_col;
					r.run_length  = cnt[7:0];
					out_recs.push_back(r);
					px_done = px_done + cnt;
					sum     = 32'(cur_col) + cnt;
					cur_row = 16'(32'(cur_row) + sum / w);
					cur_col = 16'(sum % w);
					if (rle_type()) begin
						if (pkt_rep || pkt_left <= 1) pkt_left = '0;
						else pkt_left = pkt_left - 8'd1;
						if (pkt_left == 0) phase = P_PACKET;
					end
					if (px_done >= total) begin
						r = make_rec(KIND_DONE, ST_OK);
						r.image_width  = w[15:0];
						r.image_height = h[15:0];
						out_recs.push_back(r);
						phase = P_IDLE;
					end
				end
			end
			default: ;
		endcase
		if (it.end_of_file) begin
			if (phase != P_IDLE) out_recs.push_back(make_rec(KIND_ERROR, ST_SHORT));
			restart_file();
		end
		if (out_recs.size() > 0) out_recs[$].last_of_step = 1'b1;
		foreach (out_recs[i]) expected_recs.push_back(out_recs[i]);
	endfunction

	// file builders
	function automatic void push_byte(logic [7:0] b, bit eof = 0);
		in_item_t it;
		it.file_byte   = b;
		it.end_of_file = eof;
		pending_bytes.push_back(it);
		pushed_total++;
	endfunction

	function automatic void push_header(logic [7:0] idlen, logic [7:0] maptype,
		logic [7:0] itype, logic [15:0] mfirst, logic [15:0] mlen,
		logic [7:0] mbits, logic [15:0] yorg, logic [15:0] w, logic [15:0] h,
		logic [7:0] depth, logic [7:0] desc);
		push_byte(idlen); push_byte(maptype); push_byte(itype);
		push_byte(mfirst[7:0]); push_byte(mfirst[15:8]);
		push_byte(mlen[7:0]); push_byte(mlen[15:8]); push_byte(mbits);
		push_byte(8'($urandom)); push_byte(8'($urandom));
		push_byte(yorg[7:0]); push_byte(yorg[15:8]);
		push_byte(w[7:0]); push_byte(w[15:8]);
		push_byte(h[7:0]); push_byte(h[15:8]);
		push_byte(depth); push_byte(desc);
	endfunction

	// n random body bytes, the last one with end of file
	function automatic void push_body(int n);
		for (int i = 0; i < n; i++) push_byte(8'($urandom), i == n - 1);
	endfunction

	// well-formed file with random content; mode picks the variant
	function automatic void push_file(int mode);
		logic [7:0]  itype, depth, mbits, maptype;
		logic [15:0] w, h, yorg;
		int          entries, esz, psz, npix, body;
		bit          rle, mapped;
		itype   = mode[0] ? (mode[1] ? 8'd9 : 8'd1) : (mode[1] ? 8'd10 : 8'd2);
		mapped  = itype == 8'd1 || itype == 8'd9;
		rle     = itype == 8'd9 || itype == 8'd10;
		w       = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
		h       = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(1, 5));
		if (w == 0) w = 16'd1;
		if (h == 0) h = 16'd1;
		yorg    = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
		depth   = $urandom_range(0, 1) ? 8'd24 : 8'd32;
		mbits   = $urandom_range(0, 1) ? 8'd24 : 8'd32;
		entries = mapped ? $urandom_range(0, 6) : 0;
		maptype = (mapped && entries != 0) ? 8'($urandom_range(1, 255)) : 8'd0;
		if (!mapped) mbits = 8'($urandom);
		push_header(8'($urandom), maptype, itype, 16'd0, 16'(entries), mbits,
		            yorg, w, h, depth, 8'($urandom));
		esz  = mbits / 8;
		for (int i = 0; i < entries * esz; i++) push_byte(8'($urandom));
		psz  = mapped ? 1 : depth / 8;
		npix = int'(w) * int'(h);
		if (npix > 40) npix = 40;
		body = 0;
		// pixel data, cut short now and then
		for (int p = 0; p < npix && body < 120; ) begin
			int k;
			k = 1;
			if (rle) begin
				if ($urandom_range(0, 1)) begin
					k = $urandom_range(1, 128);
					push_byte(8'(k + 127));
				end else begin
					k = $urandom_range(1, 4);
					push_byte(8'(k - 1));
					k = -k;
				end
				body++;
			end
			for (int j = 0; j < (k < 0 ? -k : 1); j++) begin
				for (int q = 0; q < psz; q++) begin
					push_byte(mapped ? 8'($urandom_range(0, entries + 1)) : 8'($urandom));
					body++;
				end
			end
			p += (k < 0 ? -k : k);
		end
		// trailer or cut: end of file always closes the file
		if ($urandom_range(0, 5) == 0 && pending_bytes.size() > 0)
			pending_bytes[$].end_of_file = 1'b1;
		else
			push_body($urandom_range(1, 3));
	endfunction

	// driver
	int idle_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data  <= '0;
			idle_left   <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data);
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (idle_left > 0) begin
					in_ch.valid <= 1'b0;
					idle_left   <= idle_left - 1;
				end else if (!no_idle && $urandom_range(0, 9) == 0) begin
					in_ch.valid <= 1'b0;
					idle_left   <= $urandom_range(0, 10);
				end else if (hold_until_drained && expected_recs.size() != 0) begin
					in_ch.valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.data  <= pending_bytes.pop_front();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor and record check
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left   <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_recs.size() == 0) begin
					errors++;
					if (mismatches++ < 10)
						$display("unexpected record %p", out_ch.data);
				end else begin
					rec_t e;
					e = expected_recs.pop_front();
					if (e !== out_ch.data) begin
						errors++;
						if (mismatches++ < 10)
							$display("record mismatch: exp %p got %p", e, out_ch.data);
					end
				end
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left   <= stall_left - 1;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				out_ch.ready <= 1'b0;
				stall_left   <= $urandom_range(0, 10);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// timeout
	initial begin
		#2000000;
		$display("tb: done, errors");
		$finish;
	end

	// stimulus
	initial begin
		int mode;
		errors = 0;
		mismatches = 0;
		no_idle = 0;
		hold_until_drained = 0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		out_ch.ready = 1'b0;
		decode_reset();

		// directed: zero width, bad type, bad depth, a 1x1 raw file
		push_header(8'd0, 8'd0, 8'd2, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd1, 8'd24, 8'd0);
		push_byte(8'hFF, 1);
		push_header(8'hFF, 8'hFF, 8'd3, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF,
		            16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
		push_byte(8'h00, 1);
		push_header(8'd0, 8'd0, 8'd10, 16'd0, 16'd0, 8'd0, 16'd0, 16'd2, 16'd2, 8'd16, 8'd0);
		push_byte(8'h00, 1);
		push_header(8'd0, 8'd0, 8'd2, 16'd0, 16'd0, 8'd0, 16'd0, 16'd1, 16'd1, 8'd32, 8'd0);
		push_byte(8'h12); push_byte(8'h34); push_byte(8'h56); push_byte(8'h78, 1);
		wait (arst_n);
		for (mode = 0; mode < 4; mode++) push_file(mode);

		// pause until all records are in, then go on
		wait (pending_bytes.size() == 0);
		hold_until_drained = 1;
		push_file(1);
		wait (pending_bytes.size() == 0 && expected_recs.size() == 0);
		hold_until_drained = 0;

		// random files, with a few broken headers and noise
		while (pushed_total < N_TARGET) begin
			case ($urandom_range(0, 9))
				0: begin
					push_header(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
					            16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
					            16'($urandom), 8'($urandom), 8'($urandom));
					push_body($urandom_range(1, 4));
				end
				1: push_body($urandom_range(1, 20));
				default: push_file($urandom_range(0, 3));
			endcase
		end
		// last stretch with no idling
		wait (pending_bytes.size() < 150);
		no_idle = 1;
		wait (pending_bytes.size() == 0);
		wait (expected_recs.size() == 0 && !in_ch.valid);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_recs.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/tga_pkg.sv
sv/tga_stream_if.sv
sv/tga_image_decoder.sv
tb/sv/tb.sv
